// File: sv/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/dfurc_pkg.sv
// Types, codes and defaults of the DFU request controller.
`timescale 1ns / 1ps
package dfurc_pkg;

  localparam int unsigned PAGE_BYTES_DEF  = 4096;
  localparam int unsigned BLOCK_BYTES_DEF = 64;

  localparam logic [15:0] RQ_GETSTATUS = 16'h03A1;
  localparam logic [15:0] RQ_GETSTATE  = 16'h05A1;
  localparam logic [15:0] RQ_DNLOAD    = 16'h0121;
  localparam logic [15:0] RQ_UPLOAD    = 16'h02A1;
  localparam logic [15:0] RQ_CLRSTATUS = 16'h0421;
  localparam logic [15:0] RQ_ABORT     = 16'h0621;

  localparam logic [15:0] STATUS_LEN = 16'd6;
  localparam logic [15:0] STATE_LEN  = 16'd1;

  localparam logic [31:0] REGION_BASE_RST   = 32'h8000_1000;
  localparam logic [31:0] REGION_END_RST    = 32'h8010_0000;
  localparam logic [7:0]  POLL_ERASE_RST    = 8'd50;
  localparam logic [7:0]  POLL_PROGRAM_RST  = 8'd8;
  localparam logic [7:0]  POLL_MANIFEST_RST = 8'd100;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REGION_BASE   = 3'd0,
    CFG_REGION_END    = 3'd1,
    CFG_POLL_ERASE    = 3'd2,
    CFG_POLL_PROGRAM  = 3'd3,
    CFG_POLL_MANIFEST = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ACT_REQUEST    = 2'd0,
    ACT_PROG_DONE  = 2'd1,
    ACT_CHECK_DONE = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_SYNC  = 3'd1,
    ST_BUSY  = 3'd2,
    ST_DIDLE = 3'd3,
    ST_MANI  = 3'd4,
    ST_ERROR = 3'd5
  } dfu_state_e;

  typedef enum logic [1:0] {
    SC_OK     = 2'd0,
    SC_ADDR   = 2'd1,
    SC_VERIFY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SRC_NONE   = 2'd0,
    SRC_STATUS = 2'd1,
    SRC_STATE  = 2'd2,
    SRC_FLASH  = 2'd3
  } reply_src_e;

  typedef struct packed {
    logic [31:0] region_base;
    logic [31:0] region_end;
    logic [7:0]  poll_erase;
    logic [7:0]  poll_program;
    logic [7:0]  poll_manifest;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] request_code;
    logic [15:0] w_value;
    logic [15:0] w_length;
    logic        crc_ok;
  } item_t;

  typedef struct packed {
    logic [6:0]  reply_len;
    logic [1:0]  reply_source;
    logic [31:0] read_addr;
    logic [1:0]  status_code;
    logic [7:0]  poll_ms;
    logic [2:0]  dfu_state;
    logic [6:0]  capture_len;
    logic        program_go;
    logic [31:0] program_addr;
    logic [6:0]  program_len;
    logic        verify_go;
    logic        reboot;
  } result_t;

endpackage

// File: sv/dfurc_in_if.sv
// Input channel: request and event items.
`timescale 1ns / 1ps
interface dfurc_in_if
  import dfurc_pkg::*;
;
  logic  valid;
  logic  ready;
  item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// File: sv/dfurc_out_if.sv
// Output channel: result items.
`timescale 1ns / 1ps
interface dfurc_out_if
  import dfurc_pkg::*;
;
  logic    valid;
  logic    ready;
  result_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// File: sv/dfurc_cfg_regs.sv
// Configuration register file with write port.
`timescale 1ns / 1ps
module dfurc_cfg_regs
  import dfurc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 we_i,
  input  logic [CFG_IDX_W-1:0] idx_i,
  input  logic [31:0]          wdata_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (cfg_idx_e'(idx_i))
        CFG_REGION_BASE:   cfg_d.region_base   = wdata_i;
        CFG_REGION_END:    cfg_d.region_end    = wdata_i;
        CFG_POLL_ERASE:    cfg_d.poll_erase    = wdata_i[7:0];
        CFG_POLL_PROGRAM:  cfg_d.poll_program  = wdata_i[7:0];
        CFG_POLL_MANIFEST: cfg_d.poll_manifest = wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.region_base   <= REGION_BASE_RST;
      cfg_q.region_end    <= REGION_END_RST;
      cfg_q.poll_erase    <= POLL_ERASE_RST;
      cfg_q.poll_program  <= POLL_PROGRAM_RST;
      cfg_q.poll_manifest <= POLL_MANIFEST_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/dfurc_core.sv
// Request decode, protocol state and result formation.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dfurc_core
  import dfurc_pkg::*;
#(
  parameter int unsigned PAGE_BYTES  = PAGE_BYTES_DEF,
  parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    advance_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  // page size is a power of two
  localparam int unsigned PW = $clog2(PAGE_BYTES);
  localparam int unsigned BW = $clog2(BLOCK_BYTES + 1);
  localparam int unsigned AW = 34;
  localparam logic [AW-1:0] BLK_A = AW'(BLOCK_BYTES);
  localparam logic [15:0]   BLK_L = 16'(BLOCK_BYTES);

  dfu_state_e  state_q, state_d;
  status_e     status_q, status_d;
  logic [7:0]  poll_q, poll_d;
  logic [31:0] blk_addr_q, blk_addr_d;
  logic [6:0]  blk_len_q, blk_len_d;
  logic        prog_armed_q, prog_armed_d;
  logic        verify_armed_q, verify_armed_d;

  logic [AW-1:0] addr;
  logic [AW-1:0] end_a;
  logic [AW-1:0] up_diff;
  logic [BW-1:0] up_n;
  logic          guard_bad;

  assign addr      = AW'(cfg_i.region_base) + AW'(item_i.w_value) * BLK_A;
  assign end_a     = AW'(cfg_i.region_end);
  assign up_diff   = end_a - addr;
  assign guard_bad = (item_i.w_length > BLK_L) || ((addr + BLK_A) > end_a);

  always_comb begin
    up_n = (item_i.w_length < BLK_L) ? BW'(item_i.w_length) : BW'(BLOCK_BYTES);
    if (addr >= end_a) begin
      up_n = '0;
    end else if ((addr + AW'(up_n)) > end_a) begin
      up_n = BW'(up_diff);
    end
  end

  always_comb begin
    state_d        = state_q;
    status_d       = status_q;
    poll_d         = poll_q;
    blk_addr_d     = blk_addr_q;
    blk_len_d      = blk_len_q;
    prog_armed_d   = prog_armed_q;
    verify_armed_d = verify_armed_q;
    res_o          = '0;

    case (action_e'(item_i.action))
      ACT_PROG_DONE: begin
        if (prog_armed_q) begin
          prog_armed_d = 1'b0;
          blk_addr_d   = '0;
          status_d     = SC_OK;
          poll_d       = '0;
          state_d      = ST_DIDLE;
        end
      end
      ACT_CHECK_DONE: begin
        if (verify_armed_q) begin
          verify_armed_d = 1'b0;
          if (item_i.crc_ok) begin
            res_o.reboot = 1'b1;
            state_d      = ST_IDLE;
            status_d     = SC_OK;
            poll_d       = '0;
            blk_addr_d   = '0;
            blk_len_d    = '0;
            prog_armed_d = 1'b0;
          end else begin
            status_d = SC_VERIFY;
            state_d  = ST_ERROR;
          end
        end
      end
      ACT_REQUEST: begin
        case (item_i.request_code)
          RQ_GETSTATUS: begin
            if (state_q == ST_SYNC) begin
              status_d         = SC_OK;
              poll_d           = (blk_addr_q[PW-1:0] == '0) ? cfg_i.poll_erase
                                                            : cfg_i.poll_program;
              state_d          = ST_BUSY;
              prog_armed_d     = 1'b1;
              res_o.program_go = 1'b1;
            end
            res_o.reply_len    = (item_i.w_length < STATUS_LEN) ? item_i.w_length[6:0]
                                                                : STATUS_LEN[6:0];
            res_o.reply_source = SRC_STATUS;
          end
          RQ_GETSTATE: begin
            res_o.reply_len    = (item_i.w_length < STATE_LEN) ? item_i.w_length[6:0]
                                                               : STATE_LEN[6:0];
            res_o.reply_source = SRC_STATE;
          end
          RQ_DNLOAD: begin
            if (item_i.w_length != '0) begin
              if (guard_bad) begin
                status_d = SC_ADDR;
                state_d  = ST_ERROR;
              end else begin
                prog_armed_d      = 1'b0;
                blk_addr_d        = addr[31:0];
                blk_len_d         = item_i.w_length[6:0];
                res_o.capture_len = item_i.w_length[6:0];
                state_d           = ST_SYNC;
              end
            end else begin
              status_d        = SC_OK;
              poll_d          = cfg_i.poll_manifest;
              state_d         = ST_MANI;
              verify_armed_d  = 1'b1;
              res_o.verify_go = 1'b1;
            end
          end
          RQ_UPLOAD: begin
            res_o.reply_len    = 7'(up_n);
            res_o.reply_source = SRC_FLASH;
            res_o.read_addr    = addr[31:0];
          end
          RQ_CLRSTATUS, RQ_ABORT: begin
            state_d        = ST_IDLE;
            status_d       = SC_OK;
            poll_d         = '0;
            blk_addr_d     = '0;
            blk_len_d      = '0;
            prog_armed_d   = 1'b0;
            verify_armed_d = 1'b0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    res_o.status_code  = status_d;
    res_o.poll_ms      = poll_d;
    res_o.dfu_state    = state_d;
    res_o.program_addr = blk_addr_d;
    res_o.program_len  = blk_len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      status_q       <= SC_OK;
      poll_q         <= '0;
      blk_addr_q     <= '0;
      blk_len_q      <= '0;
      prog_armed_q   <= 1'b0;
      verify_armed_q <= 1'b0;
    end else if (advance_i) begin
      state_q        <= state_d;
      status_q       <= status_d;
      poll_q         <= poll_d;
      blk_addr_q     <= blk_addr_d;
      blk_len_q      <= blk_len_d;
      prog_armed_q   <= prog_armed_d;
      verify_armed_q <= verify_armed_d;
    end
  end

  `ASSERT_NEXT(a_prog_arms_busy, clk_i, rst_ni, advance_i && res_o.program_go,
               state_q == ST_BUSY && prog_armed_q)
  `ASSERT_NEXT(a_reboot_clears, clk_i, rst_ni, advance_i && res_o.reboot,
               state_q == ST_IDLE && !verify_armed_q && !prog_armed_q)
  `ASSERT_NEXT(a_state_holds, clk_i, rst_ni, !advance_i,
               $stable(state_q) && $stable(blk_addr_q) && $stable(prog_armed_q))
  `ASSERT_NEXT(a_verify_arms_mani, clk_i, rst_ni, advance_i && res_o.verify_go,
               state_q == ST_MANI && verify_armed_q)

endmodule

// File: sv/dfu_request_controller.sv
// Top level of the DFU class request controller.
//
//   channel   dir  handshake     payload
//   in_ch_i   in   valid/ready   action, request_code, w_value, w_length, crc_ok
//   out_ch_o  out  valid/ready   reply and status fields, one per input item
//   cfg_*     in   we only       register index and 32-bit write data
//
// One item per cycle while results are taken; an accepted item passes the input
// register, then the decode logic, then the result register.
// Reset clears the protocol state and loads the register defaults.
// A stalled result holds the input register; ready drops only while both
// registers are full and the result is not taken.
`timescale 1ns / 1ps
module dfu_request_controller
  import dfurc_pkg::*;
#(
  parameter int unsigned PAGE_BYTES  = PAGE_BYTES_DEF,
  parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  dfurc_in_if.sink             in_ch_i,
  dfurc_out_if.source          out_ch_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_wdata_i
);

  cfg_t    cfg;
  result_t res;

  logic    in_valid_q;
  item_t   in_item_q;
  logic    out_valid_q;
  result_t out_res_q;
  logic    advance;
  logic    in_take;

  assign advance       = in_valid_q && (!out_valid_q || out_ch_o.ready);
  assign in_ch_i.ready = !in_valid_q || advance;
  assign in_take       = in_ch_i.valid && in_ch_i.ready;

  dfurc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  dfurc_core #(
    .PAGE_BYTES  (PAGE_BYTES),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (in_item_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ch_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_ch_i.item;
    end
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign out_ch_o.valid = out_valid_q;
  assign out_ch_o.item  = out_res_q;

endmodule
